/* src/button_click_classifier_defines.svh */
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion, disabled while the active-low reset is asserted.
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared widths, event codes, register indexes and state/config records.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Timestamp width; time differences wrap modulo 2^TIME_BITS.
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CFG_BITS-1:0]  t_cfg_val;

    // Event codes on the result item
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } t_event;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_DBL_WINDOW = 2'd2,
        REG_DBL_ENABLE = 2'd3
    } t_reg_idx;

    localparam t_cfg_val DEBOUNCE_RST   = 16'd25;
    localparam t_cfg_val LONG_PRESS_RST = 16'd600;
    localparam t_cfg_val DBL_WINDOW_RST = 16'd350;

    typedef struct packed {
        t_cfg_val debounce_time;
        t_cfg_val long_press_time;
        t_cfg_val double_window;
        logic     double_enable;
    } t_cfg;

    typedef struct packed {
        logic  raw_sample;
        t_time change_time;
        logic  stable_level;
        t_time press_time;
        t_time release_time;
        logic  press_handled;
        logic  awaiting_second;
    } t_state;

endpackage

/* src/bcc_classify.sv */
// ----------------------------------------------------------------------------
// Button click classifier step logic
// Debounce, press classification and next state for one sample.
// ----------------------------------------------------------------------------
module bcc_classify (
    input  bcc_pkg::t_cfg   i_cfg,
    input  bcc_pkg::t_state i_state,
    input  logic            i_level,
    input  bcc_pkg::t_time  i_now,
    output bcc_pkg::t_state o_state,
    output bcc_pkg::t_event o_event
);

    logic           changed;
    bcc_pkg::t_time db_elapsed;
    bcc_pkg::t_time rel_elapsed;
    bcc_pkg::t_time prs_elapsed;
    bcc_pkg::t_time rel_elapsed_n;
    bcc_pkg::t_time prs_elapsed_n;
    logic           take;
    logic           new_press;
    logic           new_release;

    // Wrapping differences against stored timestamps, all in parallel
    assign changed     = (i_level != i_state.raw_sample);
    assign db_elapsed  = changed ? '0 : (i_now - i_state.change_time);
    assign rel_elapsed = i_now - i_state.release_time;
    assign prs_elapsed = i_now - i_state.press_time;
    assign take        = (db_elapsed >= bcc_pkg::t_time'(i_cfg.debounce_time)) &&
                         (i_level != i_state.stable_level);
    assign new_press   = take && i_level;
    assign new_release = take && !i_level;
    // A timestamp taken this sample gives zero elapsed time
    assign prs_elapsed_n = new_press   ? '0 : prs_elapsed;
    assign rel_elapsed_n = new_release ? '0 : rel_elapsed;

    // Classification, first matching rule wins
    always_comb begin
        logic done;
        done    = 1'b0;
        o_state = i_state;
        o_event = bcc_pkg::EV_NONE;

        o_state.raw_sample = i_level;
        if (changed) begin
            o_state.change_time = i_now;
        end

        if (take) begin
            o_state.stable_level = i_level;
            if (i_level) begin
                o_state.press_time    = i_now;
                o_state.press_handled = 1'b0;
                if (i_state.awaiting_second) begin
                    o_state.awaiting_second = 1'b0;
                    done = 1'b1;
                    if (rel_elapsed < bcc_pkg::t_time'(i_cfg.double_window)) begin
                        o_state.press_handled = 1'b1;
                        o_event = bcc_pkg::EV_DOUBLE;
                    end else begin
                        o_event = bcc_pkg::EV_SHORT;
                    end
                end
            end else begin
                o_state.release_time = i_now;
                if (!i_state.press_handled) begin
                    if (!i_cfg.double_enable) begin
                        o_event = bcc_pkg::EV_SHORT;
                        done    = 1'b1;
                    end else begin
                        o_state.awaiting_second = 1'b1;
                    end
                end
            end
        end

        // Held for at least the long threshold
        if (!done && o_state.stable_level && !o_state.press_handled &&
            (prs_elapsed_n >= bcc_pkg::t_time'(i_cfg.long_press_time))) begin
            o_state.press_handled   = 1'b1;
            o_state.awaiting_second = 1'b0;
            o_event = bcc_pkg::EV_LONG;
            done    = 1'b1;
        end

        // Pending single press timed out
        if (!done && o_state.awaiting_second && !o_state.stable_level &&
            (rel_elapsed_n >= bcc_pkg::t_time'(i_cfg.double_window))) begin
            o_state.awaiting_second = 1'b0;
            o_event = bcc_pkg::EV_SHORT;
        end
    end

endmodule

/* src/button_click_classifier.sv */
// ----------------------------------------------------------------------------
// Button click classifier
// Debounced push-button short, long and double press detector.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one item per button sample, carrying the raw level and a
//   free-running millisecond timestamp. Output stream: exactly one item per
//   input item, an event code (none, short, long, double).
//   Config channel: register index and 16-bit data, always ready; write only
//   while no item is in flight.
//   Pipeline: an accepted item passes through two register stages, the input
//   register and the result register, before it is presented on the output.
//   Throughput: one item per cycle while the receiver is ready. The classifier
//   state updates in compare/subtract logic, so each sample sees the previous one.
//   Stall: the result register holds while the receiver stalls; the input
//   register still takes one more item, then input ready drops.
//   Reset: synchronous, active low; clears the classifier state and both valid
//   flags, and loads the register defaults (25, 600, 350, doubles off).
// ----------------------------------------------------------------------------
`include "button_click_classifier_defines.svh"

module button_click_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [0] pressed_level, [32:1] time_now, zero pad
    // Event stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [1:0] event_code, zero pad
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bcc_pkg::t_cfg   r_cfg;
    bcc_pkg::t_state r_st;
    bcc_pkg::t_state n_st;
    bcc_pkg::t_event n_ev;
    bcc_pkg::t_event r_ev;
    logic            r_in_valid;
    logic            r_level;
    bcc_pkg::t_time  r_now;
    logic            r_out_valid;
    logic            advance;
    logic            in_accept;

    // Pipeline flow control
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= bcc_pkg::DEBOUNCE_RST;
            r_cfg.long_press_time <= bcc_pkg::LONG_PRESS_RST;
            r_cfg.double_window   <= bcc_pkg::DBL_WINDOW_RST;
            r_cfg.double_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (bcc_pkg::t_reg_idx'(i_cfg_index))
                bcc_pkg::REG_DEBOUNCE:   r_cfg.debounce_time   <= i_cfg_data;
                bcc_pkg::REG_LONG_PRESS: r_cfg.long_press_time <= i_cfg_data;
                bcc_pkg::REG_DBL_WINDOW: r_cfg.double_window   <= i_cfg_data;
                bcc_pkg::REG_DBL_ENABLE: r_cfg.double_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_level <= i_s_axis_tdata[0];
            r_now   <= i_s_axis_tdata[bcc_pkg::TIME_BITS:1];
        end
    end

    // Classification step
    bcc_classify u_classify (
        .i_cfg   (r_cfg),
        .i_state (r_st),
        .i_level (r_level),
        .i_now   (r_now),
        .o_state (n_st),
        .o_event (n_ev)
    );

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_ev <= n_ev;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_ev};

    // Checks
    `BCC_ASSERT(a_step_to_result, i_clk, i_rst_n, (r_in_valid && advance) |=> r_out_valid, "sample in input register did not reach the result register")
    `BCC_ASSERT(a_long_marks_handled, i_clk, i_rst_n, (r_in_valid && advance && n_ev == bcc_pkg::EV_LONG) |=> r_st.press_handled, "long press left the press unhandled")
    `BCC_ASSERT_ALWAYS(a_wait_while_released, i_clk, r_st.awaiting_second |-> !r_st.stable_level, "awaiting second press while button is down")

endmodule
